// ----- rtl/dpsc_pkg.sv -----
package dpsc_pkg;

  localparam int unsigned DefCapacity     = 256;
  localparam int unsigned DefPayloadWidth = 32;
  localparam int unsigned KeyWidth        = 64;
  localparam int unsigned DepthWidth      = 8;
  localparam int unsigned PickWidth       = 8;
  localparam int unsigned OutPayloadWidth = 32;

  typedef enum logic [2:0] {
    OutcomeLookup  = 3'd0,
    OutcomeKept    = 3'd1,
    OutcomeUpdated = 3'd2,
    OutcomeAppend  = 3'd3,
    OutcomeEvict   = 3'd4
  } outcome_e;

  typedef enum logic {
    OpLookup = 1'b0,
    OpInsert = 1'b1
  } op_e;

endpackage

// ----- rtl/depth_preferred_search_cache_top.sv -----
// depth-preferred search cache
// command channel: present operation, key, depth, payload and three eviction
// picks with start high while busy is low; the item is taken at that edge
// and busy rises on the next cycle.
// result channel: hit_o, found_depth_o, found_payload_o and insert_outcome_o
// are valid for exactly one cycle while done_o is high; the receiver cannot
// stall, so results are never held.
// scan: the key scan reads one table entry a cycle through the single
// memory read port and stops early on a match; a full-table eviction adds
// three reads of the picked slots, a final compare and the victim write.
// busy falls the cycle after done_o, so one item runs at a time.
// reset clears the fill count and control state; table contents are not
// cleared, as only filled slots are read.
// picks are reduced modulo Capacity before use.
module depth_preferred_search_cache_top import dpsc_pkg::*; #(
  parameter int unsigned Capacity     = DefCapacity,
  parameter int unsigned PayloadWidth = DefPayloadWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [KeyWidth-1:0]        key_i,
  input  logic [DepthWidth-1:0]      depth_i,
  input  logic [PayloadWidth-1:0]    payload_i,
  input  logic [PickWidth-1:0]       pick_first_i,
  input  logic [PickWidth-1:0]       pick_second_i,
  input  logic [PickWidth-1:0]       pick_third_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [DepthWidth-1:0]      found_depth_o,
  output logic [OutPayloadWidth-1:0] found_payload_o,
  output logic [2:0]                 insert_outcome_o
);

  localparam int unsigned AddrWidth = $clog2(Capacity);
  localparam int unsigned CntWidth  = $clog2(Capacity + 1);
  localparam logic [CntWidth-1:0] CapCnt = CntWidth'(Capacity);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StScan  = 7'b0000010,
    StCheck = 7'b0000100,
    StPick  = 7'b0001000,
    StPickW = 7'b0010000,
    StEvict = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CntWidth-1:0] fill_q, fill_d;
  logic [CntWidth-1:0] idx_q, idx_d;     // next address issued
  logic                rd_vld_q, rd_vld_d;
  logic [AddrWidth-1:0] rd_idx_q, rd_idx_d;
  logic [1:0]          pick_q, pick_d;   // pick number issued

  // item registers
  logic                    op_q;
  logic [KeyWidth-1:0]     key_q;
  logic [DepthWidth-1:0]   dep_q;
  logic [PayloadWidth-1:0] pay_q;
  logic [AddrWidth-1:0]    picks_q [3];

  // best-victim tracking and result registers
  logic [AddrWidth-1:0]    vic_q, vic_d;
  logic [DepthWidth-1:0]   least_q, least_d;
  logic                    hit_q, hit_d;
  logic [DepthWidth-1:0]   fdep_q, fdep_d;
  logic [OutPayloadWidth-1:0] fpay_q, fpay_d;
  outcome_e                oc_q, oc_d;

  // memory port signals
  logic [AddrWidth-1:0]    rd_addr;
  logic [KeyWidth-1:0]     rd_key;
  logic [DepthWidth-1:0]   rd_depth;
  logic [PayloadWidth-1:0] rd_payload;
  logic                    wr_en, wr_key_en;
  logic [AddrWidth-1:0]    wr_addr;
  logic [DepthWidth-1:0]   wr_depth;
  logic [PayloadWidth-1:0] wr_payload;

  dpsc_store #(
    .Capacity     (Capacity),
    .PayloadWidth (PayloadWidth)
  ) u_store (
    .clk_i        (clk_i),
    .rd_addr_i    (rd_addr),
    .rd_key_o     (rd_key),
    .rd_depth_o   (rd_depth),
    .rd_payload_o (rd_payload),
    .wr_en_i      (wr_en),
    .wr_key_en_i  (wr_key_en),
    .wr_addr_i    (wr_addr),
    .wr_key_i     (key_q),
    .wr_depth_i   (wr_depth),
    .wr_payload_i (wr_payload)
  );

  function automatic logic [AddrWidth-1:0] pick_mod(input logic [PickWidth-1:0] p);
    logic [PickWidth+AddrWidth-1:0] w;
    w = {{AddrWidth{1'b0}}, p};
    return AddrWidth'(w % Capacity);
  endfunction

  logic start_acc;
  assign start_acc = start && !busy;
  assign busy      = (state_q != StIdle);

  // item capture: operation, key, depth, payload and reduced picks
  always_ff @(posedge clk_i) begin
    if (start_acc) begin
      op_q       <= operation_i;
      key_q      <= key_i;
      dep_q      <= depth_i;
      pay_q      <= payload_i;
      picks_q[0] <= pick_mod(pick_first_i);
      picks_q[1] <= pick_mod(pick_second_i);
      picks_q[2] <= pick_mod(pick_third_i);
    end
  end

  // stored payload sized to the result port
  logic [OutPayloadWidth-1:0] rd_pay_out;
  assign rd_pay_out = OutPayloadWidth'(rd_payload);

  // control and read-modify-write sequencing
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    pick_d     = pick_q;
    vic_d      = vic_q;
    least_d    = least_q;
    hit_d      = hit_q;
    fdep_d     = fdep_q;
    fpay_d     = fpay_q;
    oc_d       = oc_q;
    rd_addr    = idx_q[AddrWidth-1:0];
    wr_en      = 1'b0;
    wr_key_en  = 1'b0;
    wr_addr    = rd_idx_q;
    wr_depth   = dep_q;
    wr_payload = pay_q;
    unique case (state_q)
      StIdle: begin
        if (start_acc) begin
          state_d = StScan;
          idx_d   = '0;
          hit_d   = 1'b0;
          fdep_d  = '0;
          fpay_d  = '0;
        end
      end
      StScan: begin
        // issue next read while entries remain
        if (idx_q < fill_q) begin
          rd_addr  = idx_q[AddrWidth-1:0];
          rd_idx_d = idx_q[AddrWidth-1:0];
          rd_vld_d = 1'b1;
          idx_d    = idx_q + 1'b1;
        end
        // check the entry read last cycle
        if (rd_vld_q && rd_key == key_q) begin
          rd_vld_d = 1'b0;
          state_d  = StDone;
          if (op_q == OpLookup) begin
            oc_d = OutcomeLookup;
            if (rd_depth >= dep_q) begin
              hit_d  = 1'b1;
              fdep_d = rd_depth;
              fpay_d = rd_pay_out;
            end
          end else if (rd_depth < dep_q) begin
            oc_d  = OutcomeUpdated;
            wr_en = 1'b1;
          end else begin
            oc_d = OutcomeKept;
          end
        end else if (!rd_vld_q && idx_q >= fill_q) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        // key absent
        if (op_q == OpLookup) begin
          oc_d    = OutcomeLookup;
          state_d = StDone;
        end else if (fill_q < CapCnt) begin
          wr_en     = 1'b1;
          wr_key_en = 1'b1;
          wr_addr   = fill_q[AddrWidth-1:0];
          fill_d    = fill_q + 1'b1;
          oc_d      = OutcomeAppend;
          state_d   = StDone;
        end else begin
          rd_addr = picks_q[0];
          pick_d  = 2'd1;
          state_d = StPick;
        end
      end
      StPick: begin
        // pick reads pipelined one a cycle
        rd_addr = picks_q[pick_q];
        if (pick_q == 2'd1) begin
          vic_d   = picks_q[0];
          least_d = rd_depth;
        end else if (rd_depth < least_q) begin
          vic_d   = picks_q[1];
          least_d = rd_depth;
        end
        pick_d = pick_q + 1'b1;
        if (pick_q == 2'd2) begin
          state_d = StPickW;
        end
      end
      StPickW: begin
        if (rd_depth < least_q) begin
          vic_d = picks_q[2];
        end
        state_d = StEvict;
      end
      StEvict: begin
        wr_en     = 1'b1;
        wr_key_en = 1'b1;
        wr_addr   = vic_q;
        oc_d      = OutcomeEvict;
        state_d   = StDone;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      pick_q   <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      pick_q   <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    vic_q    <= vic_d;
    least_q  <= least_d;
    hit_q    <= hit_d;
    fdep_q   <= fdep_d;
    fpay_q   <= fpay_d;
    oc_q     <= oc_d;
  end

  // result ports
  assign done_o           = (state_q == StDone);
  assign hit_o            = hit_q;
  assign found_depth_o    = fdep_q;
  assign found_payload_o  = fpay_q;
  assign insert_outcome_o = oc_q;

endmodule

// ----- rtl/dpsc_store.sv -----
module dpsc_store import dpsc_pkg::*; #(
  parameter int unsigned Capacity     = DefCapacity,
  parameter int unsigned PayloadWidth = DefPayloadWidth,
  localparam int unsigned AddrWidth   = $clog2(Capacity)
) (
  input  logic                    clk_i,
  input  logic [AddrWidth-1:0]    rd_addr_i,
  output logic [KeyWidth-1:0]     rd_key_o,
  output logic [DepthWidth-1:0]   rd_depth_o,
  output logic [PayloadWidth-1:0] rd_payload_o,
  input  logic                    wr_en_i,
  input  logic                    wr_key_en_i,
  input  logic [AddrWidth-1:0]    wr_addr_i,
  input  logic [KeyWidth-1:0]     wr_key_i,
  input  logic [DepthWidth-1:0]   wr_depth_i,
  input  logic [PayloadWidth-1:0] wr_payload_i
);

  logic [KeyWidth-1:0]     key_mem     [Capacity];
  logic [DepthWidth-1:0]   depth_mem   [Capacity];
  logic [PayloadWidth-1:0] payload_mem [Capacity];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (wr_key_en_i) begin
        key_mem[wr_addr_i] <= wr_key_i;
      end
      depth_mem[wr_addr_i]   <= wr_depth_i;
      payload_mem[wr_addr_i] <= wr_payload_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_key_o     <= key_mem[rd_addr_i];
    rd_depth_o   <= depth_mem[rd_addr_i];
    rd_payload_o <= payload_mem[rd_addr_i];
  end

endmodule

// ----- dv/tb_depth_preferred_search_cache_top.sv -----
module tb_depth_preferred_search_cache_top;
  import dpsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = DefCapacity;

  typedef struct packed {
    logic                       hit;
    logic [DepthWidth-1:0]      depth;
    logic [OutPayloadWidth-1:0] payload;
    logic [2:0]                 outcome;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = 1'b0;
  logic [KeyWidth-1:0] key_i = '0;
  logic [DepthWidth-1:0] depth_i = '0;
  logic [DefPayloadWidth-1:0] payload_i = '0;
  logic [PickWidth-1:0] pick_first_i = '0;
  logic [PickWidth-1:0] pick_second_i = '0;
  logic [PickWidth-1:0] pick_third_i = '0;
  logic done_o;
  logic hit_o;
  logic [DepthWidth-1:0] found_depth_o;
  logic [OutPayloadWidth-1:0] found_payload_o;
  logic [2:0] insert_outcome_o;

  // shadow copy of the cache table
  logic [KeyWidth-1:0]        tbl_key[Slots];
  logic [DepthWidth-1:0]      tbl_depth[Slots];
  logic [DefPayloadWidth-1:0] tbl_payload[Slots];
  int unsigned                tbl_fill;

  answer_t pending_answers[$];
  int unsigned errors = 0;
  logic idle_gaps = 1'b1;

  always #5 clk_i = ~clk_i;

  depth_preferred_search_cache_top dut (.*);

  // work out the answer for one item and update the shadow table
  function automatic answer_t cache_answer(op_e op, logic [KeyWidth-1:0] k,
      logic [DepthWidth-1:0] d, logic [DefPayloadWidth-1:0] p,
      logic [PickWidth-1:0] p0, logic [PickWidth-1:0] p1, logic [PickWidth-1:0] p2);
    answer_t a;
    int slot;
    int unsigned picks[3];
    int unsigned victim;
    a = '0;
    slot = -1;
    for (int i = 0; i < tbl_fill; i++) begin
      if (slot < 0 && tbl_key[i] == k) slot = i;
    end
    if (op == OpLookup) begin
      a.outcome = OutcomeLookup;
      if (slot >= 0 && tbl_depth[slot] >= d) begin
        a.hit = 1'b1;
        a.depth = tbl_depth[slot];
        a.payload = tbl_payload[slot];
      end
    end else if (slot >= 0) begin
      if (tbl_depth[slot] < d) begin
        tbl_depth[slot] = d;
        tbl_payload[slot] = p;
        a.outcome = OutcomeUpdated;
      end else begin
        a.outcome = OutcomeKept;
      end
    end else if (tbl_fill < Slots) begin
      tbl_key[tbl_fill] = k;
      tbl_depth[tbl_fill] = d;
      tbl_payload[tbl_fill] = p;
      tbl_fill++;
      a.outcome = OutcomeAppend;
    end else begin
      picks[0] = p0 % Slots;
      picks[1] = p1 % Slots;
      picks[2] = p2 % Slots;
      victim = picks[0];
      for (int j = 1; j < 3; j++) begin
        if (tbl_depth[picks[j]] < tbl_depth[victim]) victim = picks[j];
      end
      tbl_key[victim] = k;
      tbl_depth[victim] = d;
      tbl_payload[victim] = p;
      a.outcome = OutcomeEvict;
    end
    return a;
  endfunction

  // send one item and record its expected answer
  task automatic send_item(op_e op, logic [KeyWidth-1:0] k, logic [DepthWidth-1:0] d,
      logic [DefPayloadWidth-1:0] p, logic [PickWidth-1:0] p0,
      logic [PickWidth-1:0] p1, logic [PickWidth-1:0] p2);
    while (idle_gaps && $urandom_range(99) < 33) @(posedge clk_i);
    operation_i <= op;
    key_i <= k;
    depth_i <= d;
    payload_i <= p;
    pick_first_i <= p0;
    pick_second_i <= p1;
    pick_third_i <= p2;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_answers.push_back(cache_answer(op, k, d, p, p0, p1, p2));
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // check each result against the oldest expectation
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $display("%t unexpected result: hit %0b outcome %0d", $realtime, hit_o,
                 insert_outcome_o);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (hit_o !== want.hit) begin
          $display("%t hit: expected %0b actual %0b", $realtime, want.hit, hit_o);
          errors++;
        end
        if (found_depth_o !== want.depth) begin
          $display("%t found_depth: expected %0d actual %0d", $realtime, want.depth,
                   found_depth_o);
          errors++;
        end
        if (found_payload_o !== want.payload) begin
          $display("%t found_payload: expected %h actual %h", $realtime, want.payload,
                   found_payload_o);
          errors++;
        end
        if (insert_outcome_o !== want.outcome) begin
          $display("%t insert_outcome: expected %0d actual %0d", $realtime, want.outcome,
                   insert_outcome_o);
          errors++;
        end
      end
    end
  end

  // extremes, kept and updated entries, lookup hit and miss
  task automatic test_directed();
    send_item(OpLookup, '0, '0, '0, '0, '0, '0);
    send_item(OpInsert, '0, 8'd10, 32'h1111_1111, '0, '0, '0);
    send_item(OpInsert, '1, 8'hff, '1, '1, '1, '1);
    send_item(OpLookup, '1, 8'hff, '0, '0, '0, '0);
    send_item(OpLookup, '0, 8'd10, '1, '0, '0, '0);
    send_item(OpLookup, '0, 8'd11, '0, '0, '0, '0);
    send_item(OpInsert, '0, 8'd10, 32'h2222_2222, '0, '0, '0);
    send_item(OpInsert, '0, 8'd9, 32'h3333_3333, '0, '0, '0);
    send_item(OpInsert, '0, 8'd11, 32'h4444_4444, '0, '0, '0);
    send_item(OpLookup, '0, '0, '0, '0, '0, '0);
    send_item(OpLookup, 64'h5555_aaaa_5555_aaaa, '0, '0, '0, '0, '0);
    send_item(OpInsert, 64'h8000_0000_0000_0000, '0, 32'h8000_0000, 8'h80, 8'h7f, 8'h01);
    send_item(OpLookup, 64'h8000_0000_0000_0000, '0, '0, '0, '0, '0);
  endtask

  // fill the table so that evictions start, then pause for all answers
  task automatic test_fill();
    while (tbl_fill < Slots) begin
      send_item(OpInsert, {$urandom, $urandom}, 8'($urandom), $urandom, '0, '0, '0);
    end
    wait_drained();
  endtask

  // eviction with equal and repeated picks and extreme slots
  task automatic test_evict_corners();
    send_item(OpInsert, 64'h1, 8'd0, 32'hdead_beef, 8'd5, 8'd5, 8'd5);
    send_item(OpInsert, 64'h2, 8'd0, 32'h0, 8'd0, 8'hff, 8'd5);
    send_item(OpInsert, 64'h3, 8'hff, '1, 8'hff, 8'd0, 8'd0);
    send_item(OpLookup, 64'h1, 8'd0, '0, '0, '0, '0);
    send_item(OpLookup, 64'h3, 8'hff, '0, '0, '0, '0);
  endtask

  // random mix, keys mostly drawn from what is stored
  task automatic test_random(int unsigned count);
    logic [KeyWidth-1:0] k;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 3) idle_gaps = 1'b0;
      if (n == count / 2) idle_gaps = 1'b1;
      if ($urandom_range(99) < 70 && tbl_fill > 0) k = tbl_key[$urandom_range(tbl_fill - 1)];
      else k = {$urandom, $urandom};
      send_item(op_e'($urandom_range(1)), k, 8'($urandom), $urandom, 8'($urandom),
                8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    tbl_fill = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill();
    test_evict_corners();
    test_random(1650);
    wait_drained();
    repeat (Slots + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // overall run limit
  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dpsc_pkg.sv
rtl/dpsc_store.sv
rtl/depth_preferred_search_cache_top.sv
dv/tb_depth_preferred_search_cache_top.sv
